[rtl/srd_pkg.sv]
// Shared types, constants and helper functions for the Stokes double-angle rotation block.
// Used by every module and interface of the block; depends on nothing.
package srd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FW        = 18;                  // field width, Q1.16 signed
  localparam int TOL_W     = 11;                  // tolerance register width
  localparam int EW        = FW + 2;              // widened field for abs and negate
  localparam int PW        = 2 * FW;              // product of two fields
  localparam int SW        = PW + FW + 2;         // triple product
  localparam int RW        = SW - FRAC_BITS;      // triple product after one shift
  localparam int TW        = RW + 1;              // sum before the second shift
  localparam int CW        = 64;                  // helper function width
  localparam int SQ_STEPS  = FRAC_BITS + 1;       // root bits
  localparam int SQ_W      = 2 * SQ_STEPS;        // radicand width
  localparam int RT_W      = SQ_STEPS;
  localparam int RM_W      = SQ_STEPS + 4;
  localparam int DW        = PW + 4;              // divider datapath width
  localparam int DIV_PRE   = 4;                   // stages ahead of the quotient steps

  localparam logic signed [FW-1:0] ONE   = FW'(2 ** FRAC_BITS);
  localparam logic signed [EW-1:0] ONE_E = EW'(2 ** FRAC_BITS);
  localparam logic [PW-1:0]        ONE_SQ = PW'(1) << (2 * FRAC_BITS);
  localparam logic signed [CW-1:0] HALF_C = CW'(2 ** (FRAC_BITS - 1));

  typedef enum logic [1:0] {
    MODE_IDENT,   // no rotation
    MODE_SCA,     // scattered beam on the axis
    MODE_GEN      // general geometry
  } mode_e;

  typedef struct packed {
    mode_e                  mode;
    logic signed [FW-1:0]   ci;
    logic signed [FW-1:0]   cs;
    logic signed [FW-1:0]   si;
    logic signed [FW-1:0]   ss;
    logic signed [FW-1:0]   sa;
    logic signed [FW-1:0]   ca;
    logic signed [FW-1:0]   c_ax;
    logic signed [FW-1:0]   s_ax;
    logic signed [FW-1:0]   k;
  } geo_t;

  typedef struct packed {
    mode_e                  mode;
    logic                   degen;
    logic signed [FW-1:0]   c_ax;
    logic signed [FW-1:0]   s_ax;
  } side_t;

  typedef struct packed {
    logic [DW-1:0]          d;
    logic [DW-1:0]          rem;
    logic [FRAC_BITS-1:0]   quo;
    logic                   ge;
    logic                   neg;
  } lane_t;

  typedef struct packed {
    side_t                  side;
    logic signed [FW-1:0]   c_gen;
    logic signed [FW-1:0]   s_gen;
  } rot_t;

  function automatic logic signed [FW-1:0] sat_one(input logic signed [CW-1:0] x);
    logic signed [FW-1:0] r;
    if (x > CW'(ONE)) begin
      r = ONE;
    end else if (x < -CW'(ONE)) begin
      r = -ONE;
    end else begin
      r = FW'(x);
    end
    return r;
  endfunction

  // shift right by FRAC_BITS, rounding half away from zero
  function automatic logic signed [CW-1:0] rnd_shr(input logic signed [CW-1:0] x);
    logic signed [CW-1:0] b;
    b = x + HALF_C - $signed({{(CW-1){1'b0}}, x[CW-1]});
    return b >>> FRAC_BITS;
  endfunction

  function automatic logic signed [EW-1:0] abs_ext(input logic signed [FW-1:0] x);
    logic signed [EW-1:0] e;
    e = x;
    return (e < 0) ? -e : e;
  endfunction

endpackage

[rtl/srd_if.sv]
// Valid/ready channel interfaces: configuration, geometry input, rotation result.
// Depends on srd_pkg for field widths.
interface srd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [srd_pkg::TOL_W-1:0]    near_tolerance;
  modport source (output valid, output near_tolerance, input ready);
  modport sink (input valid, input near_tolerance, output ready);
endinterface

interface srd_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [srd_pkg::FW-1:0]    sin_incident;
  logic signed [srd_pkg::FW-1:0]    cos_incident;
  logic signed [srd_pkg::FW-1:0]    sin_scattered;
  logic signed [srd_pkg::FW-1:0]    cos_scattered;
  logic signed [srd_pkg::FW-1:0]    sin_azimuth;
  logic signed [srd_pkg::FW-1:0]    cos_azimuth;
  modport source (output valid, output sin_incident, output cos_incident,
                  output sin_scattered, output cos_scattered,
                  output sin_azimuth, output cos_azimuth, input ready);
  modport sink (input valid, input sin_incident, input cos_incident,
                input sin_scattered, input cos_scattered,
                input sin_azimuth, input cos_azimuth, output ready);
endinterface

interface srd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [srd_pkg::FW-1:0]    sin_double_angle;
  logic signed [srd_pkg::FW-1:0]    cos_double_angle;
  logic                             degenerate;
  modport source (output valid, output sin_double_angle, output cos_double_angle,
                  output degenerate, input ready);
  modport sink (input valid, input sin_double_angle, input cos_double_angle,
                input degenerate, output ready);
endinterface

[rtl/srd_front.sv]
// Front pipeline: case tests and scattering cosine k, then the radicand ONE^2 - k^2.
// Depends on srd_pkg.
module srd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [srd_pkg::TOL_W-1:0]   tol_i,
  input  logic                        valid_i,
  input  srd_pkg::geo_t               geo_i,
  output logic                        valid_o,
  output srd_pkg::geo_t               geo_o,
  output logic [srd_pkg::SQ_W-1:0]    ksq_o
);
  import srd_pkg::*;

  localparam int NST = 8;

  logic [NST-1:0] v_q;
  geo_t           g1_q, g2_q, g3_q, g4_q, g5_q, g6_q, g7_q, g8_q;
  geo_t           g2_d, g7_d;

  logic signed [PW-1:0] cc2_q, p2_q, cc3_q, cc4_q, cc5_q, mhi3_q;
  logic signed [PW:0]   mlo3_q;
  logic signed [SW-1:0] sum4_q;
  logic signed [RW-1:0] r5_q;
  logic signed [TW-1:0] t6_q;
  logic [SQ_W-1:0]      ksq8_q;

  // stage 2 case tests
  logic signed [EW-1:0] aci, acs, asa, tol_e, cae, sae, csel;
  logic                 inc_axis, sca_axis, sa_small;

  always_comb begin
    aci      = abs_ext(g1_q.ci);
    acs      = abs_ext(g1_q.cs);
    asa      = abs_ext(g1_q.sa);
    tol_e    = $signed(EW'(tol_i));
    inc_axis = (ONE_E - aci) < tol_e;
    sca_axis = (ONE_E - acs) < tol_e;
    sa_small = asa < tol_e;
    cae      = g1_q.ca;
    sae      = g1_q.sa;
    csel     = (g1_q.cs < 0) ? -cae : cae;
    g2_d      = g1_q;
    g2_d.c_ax = sat_one(csel);
    g2_d.s_ax = sat_one(-sae);
    g2_d.k    = '0;
    priority if ((inc_axis && sca_axis) || sa_small || inc_axis) begin
      g2_d.mode = MODE_IDENT;
    end else if (sca_axis) begin
      g2_d.mode = MODE_SCA;
    end else begin
      g2_d.mode = MODE_GEN;
    end
  end

  // stage 3 split of ss*si for the product with ca
  logic signed [FW-1:0] ph;
  logic signed [FW:0]   pl;
  assign ph = p2_q[PW-1:FW];
  assign pl = $signed({1'b0, p2_q[FW-1:0]});

  logic signed [SW-1:0] mhi_e, mlo_e;
  assign mhi_e = mhi3_q;
  assign mlo_e = mlo3_q;

  logic signed [TW-1:0] cc5_e, r5_e;
  assign cc5_e = cc5_q;
  assign r5_e  = r5_q;

  // stage 7 rounded and saturated scattering cosine
  always_comb begin
    g7_d   = g6_q;
    g7_d.k = sat_one(rnd_shr(t6_q));
  end

  logic signed [FW-1:0] k7;
  assign k7 = g7_q.k;
  logic signed [PW-1:0] kk;
  assign kk = k7 * k7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q   <= geo_i;
      g2_q   <= g2_d;
      cc2_q  <= g1_q.ci * g1_q.cs;
      p2_q   <= g1_q.ss * g1_q.si;
      g3_q   <= g2_q;
      cc3_q  <= cc2_q;
      mhi3_q <= ph * g2_q.ca;
      mlo3_q <= pl * g2_q.ca;
      g4_q   <= g3_q;
      cc4_q  <= cc3_q;
      sum4_q <= (mhi_e <<< FW) + mlo_e;
      g5_q   <= g4_q;
      cc5_q  <= cc4_q;
      r5_q   <= RW'(rnd_shr(sum4_q));
      g6_q   <= g5_q;
      t6_q   <= cc5_e + r5_e;
      g7_q   <= g7_d;
      g8_q   <= g7_q;
      ksq8_q <= SQ_W'(ONE_SQ - $unsigned(kk));
    end
  end

  assign valid_o = v_q[NST-1];
  assign geo_o   = g8_q;
  assign ksq_o   = ksq8_q;

endmodule

[rtl/srd_sqrt.sv]
// Pipelined integer square root, one root bit per stage, geometry carried alongside.
// Depends on srd_pkg.
module srd_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  srd_pkg::geo_t               geo_i,
  input  logic [srd_pkg::SQ_W-1:0]    ksq_i,
  output logic                        valid_o,
  output srd_pkg::geo_t               geo_o,
  output logic [srd_pkg::RT_W-1:0]    q_o
);
  import srd_pkg::*;

  logic                vld_q  [SQ_STEPS];
  logic [RM_W-1:0]     rem_q  [SQ_STEPS];
  logic [RT_W-1:0]     root_q [SQ_STEPS];
  logic [SQ_W-1:0]     val_q  [SQ_STEPS];
  geo_t                geo_q  [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    logic            vld_in;
    logic [RM_W-1:0] rem_in, rem_sh, trial;
    logic [RT_W-1:0] root_in;
    logic [SQ_W-1:0] val_in;
    geo_t            geo_in;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = ksq_i;
      assign geo_in  = geo_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign val_in  = val_q[i-1];
      assign geo_in  = geo_q[i-1];
    end

    // bring down the next two radicand bits, try appending a one
    assign rem_sh = {rem_in[RM_W-3:0], val_in[SQ_W-1-2*i -: 2]};
    assign trial  = RM_W'({root_in, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[i] <= val_in;
        geo_q[i] <= geo_in;
        if (rem_sh >= trial) begin
          rem_q[i]  <= rem_sh - trial;
          root_q[i] <= {root_in[RT_W-2:0], 1'b1};
        end else begin
          rem_q[i]  <= rem_sh;
          root_q[i] <= {root_in[RT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[SQ_STEPS-1];
  assign geo_o   = geo_q[SQ_STEPS-1];
  assign q_o     = root_q[SQ_STEPS-1];

endmodule

[rtl/srd_div.sv]
// Two-lane pipelined fixed-point divider for the general case: cos and sin of the angle.
// Restoring, one quotient bit per stage, rounded and saturated. Depends on srd_pkg.
module srd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  srd_pkg::geo_t               geo_i,
  input  logic [srd_pkg::RT_W-1:0]    q_i,
  output logic                        valid_o,
  output srd_pkg::rot_t               rot_o
);
  import srd_pkg::*;

  logic [DIV_PRE-1:0] vp_q;
  side_t              sd1_q, sd2_q, sd3_q, sd4_q;

  // stage 1 products
  logic signed [PW-1:0] csk1_q, ssq1_q, sisa1_q;
  logic signed [FW-1:0] ci1_q;
  logic [RT_W-1:0]      q1_q;
  side_t                sd1_d;

  always_comb begin
    sd1_d.mode  = geo_i.mode;
    sd1_d.degen = (q_i == '0) || (geo_i.ss == '0);
    sd1_d.c_ax  = geo_i.c_ax;
    sd1_d.s_ax  = geo_i.s_ax;
  end

  // stage 2 numerators and denominators
  logic signed [DW-1:0] csk_e, ssq_e, sisa_e, ci_e, q_e;
  logic signed [DW-1:0] nc2_q, dc2_q, ns2_q, ds2_q;
  assign csk_e  = csk1_q;
  assign ssq_e  = ssq1_q;
  assign sisa_e = sisa1_q;
  assign ci_e   = ci1_q;
  assign q_e    = $signed(DW'(q1_q));

  // stage 3 magnitudes, stage 4 saturation test
  lane_t lc3_q, ls3_q, lc4_q, ls4_q;
  lane_t lc4_d, ls4_d;

  always_comb begin
    lc4_d    = lc3_q;
    lc4_d.ge = lc3_q.rem >= lc3_q.d;
    ls4_d    = ls3_q;
    ls4_d.ge = ls3_q.rem >= ls3_q.d;
  end

  function automatic lane_t mk_lane(input logic signed [DW-1:0] n,
                                    input logic signed [DW-1:0] d);
    lane_t l;
    l.rem = (n < 0) ? DW'(-n) : DW'(n);
    l.d   = (d < 0) ? DW'(-d) : DW'(d);
    l.quo = '0;
    l.ge  = 1'b0;
    l.neg = n[DW-1] ^ d[DW-1];
    return l;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
    end else if (en_i) begin
      vp_q <= {vp_q[DIV_PRE-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      csk1_q  <= geo_i.cs * geo_i.k;
      ssq1_q  <= geo_i.ss * $signed({1'b0, q_i});
      sisa1_q <= geo_i.si * geo_i.sa;
      ci1_q   <= geo_i.ci;
      q1_q    <= q_i;
      sd1_q   <= sd1_d;
      nc2_q   <= csk_e - (ci_e <<< FRAC_BITS);
      dc2_q   <= ssq_e;
      ns2_q   <= sisa_e;
      ds2_q   <= q_e <<< FRAC_BITS;
      sd2_q   <= sd1_q;
      lc3_q   <= mk_lane(nc2_q, dc2_q);
      ls3_q   <= mk_lane(ns2_q, ds2_q);
      sd3_q   <= sd2_q;
      lc4_q   <= lc4_d;
      ls4_q   <= ls4_d;
      sd4_q   <= sd3_q;
    end
  end

  // quotient steps
  logic  vs_q [FRAC_BITS];
  lane_t lc_q [FRAC_BITS];
  lane_t ls_q [FRAC_BITS];
  side_t sd_q [FRAC_BITS];

  function automatic lane_t div_step(input lane_t l);
    lane_t            o;
    logic [DW-1:0]    r2;
    o  = l;
    r2 = {l.rem[DW-2:0], 1'b0};
    if (r2 >= l.d) begin
      o.rem = r2 - l.d;
      o.quo = {l.quo[FRAC_BITS-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.quo = {l.quo[FRAC_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_step
    logic  v_in;
    lane_t lc_in, ls_in;
    side_t sd_in;
    if (i == 0) begin : g_first
      assign v_in  = vp_q[DIV_PRE-1];
      assign lc_in = lc4_q;
      assign ls_in = ls4_q;
      assign sd_in = sd4_q;
    end else begin : g_next
      assign v_in  = vs_q[i-1];
      assign lc_in = lc_q[i-1];
      assign ls_in = ls_q[i-1];
      assign sd_in = sd_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[i] <= 1'b0;
      end else if (en_i) begin
        vs_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lc_q[i] <= div_step(lc_in);
        ls_q[i] <= div_step(ls_in);
        sd_q[i] <= sd_in;
      end
    end
  end

  // final stage: round to nearest, saturate, apply sign
  function automatic logic signed [FW-1:0] div_fin(input lane_t l);
    logic [FRAC_BITS:0]   qr;
    logic signed [FW-1:0] r;
    qr = (FRAC_BITS + 1)'(l.quo) + (FRAC_BITS + 1)'({l.rem[DW-2:0], 1'b0} >= l.d);
    if (l.ge || (qr > (FRAC_BITS + 1)'(ONE))) begin
      r = ONE;
    end else begin
      r = $signed(FW'(qr));
    end
    return l.neg ? -r : r;
  endfunction

  logic vf_q;
  rot_t rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= vs_q[FRAC_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q.side  <= sd_q[FRAC_BITS-1];
      rot_q.c_gen <= div_fin(lc_q[FRAC_BITS-1]);
      rot_q.s_gen <= div_fin(ls_q[FRAC_BITS-1]);
    end
  end

  assign valid_o = vf_q;
  assign rot_o   = rot_q;

endmodule

[rtl/stokes_rotation_double_angle.sv]
// Top level of the Stokes double-angle rotation block: channels, tolerance register,
// result selection, doubling and the output register. Depends on srd_pkg, srd_if,
// srd_front, srd_sqrt and srd_div.
//
// The block takes one scattering geometry per beat (sines and cosines of the incident
// zenith, scattered zenith and relative azimuth, signed Q1.16) and returns one beat with
// sin and cos of twice the rotation angle, saturated to [-1, 1], plus a degenerate flag
// when the general case hits a zero scattering sine or scattered-zenith sine. It is one
// fully pipelined path: a new beat is taken every clock while the output side keeps up,
// and each beat passes through 8 stages for the case tests and scattering cosine, 17 for
// the root, 21 for the two parallel dividers, 2 for selection and doubling and 1 output
// register. Stalling the output freezes the whole pipe, so nothing is lost or repeated.
// The near_tolerance register (reset 1) sets the near-axis and near-zero-azimuth margin
// in LSBs; write it only while the pipe is empty. Its write channel is always ready.
module stokes_rotation_double_angle (
  input  logic        clk_i,
  input  logic        rst_ni,
  srd_cfg_if.sink     cfg_i,
  srd_in_if.sink      in_i,
  srd_out_if.source   out_o
);
  import srd_pkg::*;

  logic en;
  logic out_valid_q;

  // advance the pipe unless a finished beat is held at the output
  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready = en;
  assign cfg_i.ready = 1'b1;

  logic [TOL_W-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(1);
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.near_tolerance;
    end
  end

  geo_t geo_in;
  always_comb begin
    geo_in      = '0;
    geo_in.mode = MODE_IDENT;
    geo_in.si   = in_i.sin_incident;
    geo_in.ci   = in_i.cos_incident;
    geo_in.ss   = in_i.sin_scattered;
    geo_in.cs   = in_i.cos_scattered;
    geo_in.sa   = in_i.sin_azimuth;
    geo_in.ca   = in_i.cos_azimuth;
  end

  logic            fr_valid, sq_valid, dv_valid;
  geo_t            fr_geo, sq_geo;
  logic [SQ_W-1:0] fr_ksq;
  logic [RT_W-1:0] sq_q;
  rot_t            dv_rot;

  srd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tol_i   (tol_q),
    .valid_i (in_i.valid),
    .geo_i   (geo_in),
    .valid_o (fr_valid),
    .geo_o   (fr_geo),
    .ksq_o   (fr_ksq)
  );

  srd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .geo_i   (fr_geo),
    .ksq_i   (fr_ksq),
    .valid_o (sq_valid),
    .geo_o   (sq_geo),
    .q_o     (sq_q)
  );

  srd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .geo_i   (sq_geo),
    .q_i     (sq_q),
    .valid_o (dv_valid),
    .rot_o   (dv_rot)
  );

  // select the angle's cos and sin by case; the incident-axis case is the identity
  logic signed [FW-1:0] c_d, s_d;
  logic                 dg_d;
  always_comb begin
    dg_d = 1'b0;
    unique case (dv_rot.side.mode)
      MODE_SCA: begin
        c_d = dv_rot.side.c_ax;
        s_d = dv_rot.side.s_ax;
      end
      MODE_GEN: begin
        if (dv_rot.side.degen) begin
          dg_d = 1'b1;
          c_d  = ONE;
          s_d  = '0;
        end else begin
          c_d = dv_rot.c_gen;
          s_d = -dv_rot.s_gen;
        end
      end
      default: begin
        c_d = ONE;
        s_d = '0;
      end
    endcase
  end

  logic                 v1_q, v2_q;
  logic signed [FW-1:0] c1_q, s1_q;
  logic                 dg1_q, dg2_q;
  logic signed [PW-1:0] ps2_q, pc2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= dv_valid;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // double: sin2 = round(2sc), cos2 = round(2cc) - 1, both saturated
  logic signed [CW-1:0] ps_e, pc_e;
  assign ps_e = ps2_q;
  assign pc_e = pc2_q;

  logic signed [FW-1:0] sin_q, cos_q;
  logic                 dg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q  <= c_d;
      s1_q  <= s_d;
      dg1_q <= dg_d;
      ps2_q <= s1_q * c1_q;
      pc2_q <= c1_q * c1_q;
      dg2_q <= dg1_q;
      sin_q <= sat_one(rnd_shr(ps_e <<< 1));
      cos_q <= sat_one(rnd_shr(pc_e <<< 1) - CW'(ONE));
      dg_q  <= dg2_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.sin_double_angle = sin_q;
  assign out_o.cos_double_angle = cos_q;
  assign out_o.degenerate       = dg_q;

  a_degen_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && dg_q) |-> (sin_q == '0 && cos_q == ONE))
    else $error("degenerate beat without identity rotation");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sin_q <= ONE && sin_q >= -ONE && cos_q <= ONE && cos_q >= -ONE))
    else $error("result outside [-1, 1]");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(fr_valid) && $stable(sq_valid) && $stable(dv_valid) && out_valid_q))
    else $error("pipeline moved during an output stall");

endmodule

[tb/tb_rotation_pkg.sv]
`timescale 1ns / 1ps
// Golden arithmetic for the Stokes double-angle rotation testbench.
// Depends on srd_pkg for field widths and the fixed-point one.
package tb_rotation_pkg;
  import srd_pkg::*;

  typedef struct packed {
    logic signed [FW-1:0] si;
    logic signed [FW-1:0] ci;
    logic signed [FW-1:0] ss;
    logic signed [FW-1:0] cs;
    logic signed [FW-1:0] sa;
    logic signed [FW-1:0] ca;
  } geometry_t;

  typedef struct packed {
    logic signed [FW-1:0] s2;
    logic signed [FW-1:0] c2;
    logic                 degen;
  } rotation_t;

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // shift right by FRAC_BITS, half away from zero
  function automatic longint round_shift(longint x);
    longint h;
    h = longint'(1) << (FRAC_BITS - 1);
    if (x >= 0) return (x + h) >>> FRAC_BITS;
    return -((-x + h) >>> FRAC_BITS);
  endfunction

  function automatic longint int_root(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // fixed-point quotient, rounded and clipped to one
  function automatic longint frac_quotient(longint num, longint den);
    longint one;
    longint n;
    longint d;
    longint q;
    longint rm;
    longint r;
    bit neg;
    one = longint'(1) << FRAC_BITS;
    neg = (num < 0) != (den < 0);
    n = mag(num);
    d = mag(den);
    q = 0;
    if (n >= d) begin
      r = one;
    end else begin
      rm = n;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rm = rm << 1;
        q = q << 1;
        if (rm >= d) begin
          rm = rm - d;
          q = q | 1;
        end
      end
      if ((rm << 1) >= d) q++;
      r = q > one ? one : q;
    end
    return neg ? -r : r;
  endfunction

  function automatic rotation_t predict_rotation(geometry_t g, longint tol);
    longint one;
    longint si, ci, ss, cs, sa, ca;
    longint s2, c2, c, s, k, q;
    bit inc_ax, sca_ax, ok;
    rotation_t r;
    one = longint'(1) << FRAC_BITS;
    si = g.si; ci = g.ci; ss = g.ss; cs = g.cs; sa = g.sa; ca = g.ca;
    inc_ax = one - mag(ci) < tol;
    sca_ax = one - mag(cs) < tol;
    s2 = 0;
    c2 = one;
    r.degen = 1'b0;
    if (!((inc_ax && sca_ax) || mag(sa) < tol)) begin
      ok = 1;
      if (inc_ax) begin
        c = one;
        s = 0;
      end else if (sca_ax) begin
        c = clip(cs >= 0 ? ca : -ca, -one, one);
        s = clip(-sa, -one, one);
      end else begin
        k = round_shift(ci * cs + round_shift(ss * si * ca));
        k = clip(k, -one, one);
        q = int_root(one * one - k * k);
        if (q == 0 || ss == 0) begin
          ok = 0;
          r.degen = 1'b1;
        end else begin
          c = frac_quotient(cs * k - ci * one, ss * q);
          s = -frac_quotient(si * sa, q * one);
        end
      end
      if (ok) begin
        s2 = round_shift(2 * s * c);
        c2 = round_shift(2 * c * c) - one;
      end
    end
    r.s2 = FW'(clip(s2, -one, one));
    r.c2 = FW'(clip(c2, -one, one));
    return r;
  endfunction
endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top of the Stokes double-angle rotation testbench: clock, reset, stimulus, checker.
// Depends on srd_pkg, srd_if, tb_rotation_pkg and the block under test.
module tb_top;
  import srd_pkg::*;
  import tb_rotation_pkg::*;

  localparam int ONE_I = 65536;
  localparam int PIPE_DRAIN = 80;     // well past the depth of the pipe
  localparam int STALL_LIMIT = 5000;  // idle cycles before giving up

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  srd_cfg_if cfg_bus();
  srd_in_if  geo_bus();
  srd_out_if rot_bus();

  stokes_rotation_double_angle dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus.sink),
    .in_i   (geo_bus.sink),
    .out_o  (rot_bus.source)
  );

  rotation_t expected_rotations[$];
  int  tolerance = 1;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  error_count = 0;
  int  idle_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hold every input at a known value from time zero.
  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.near_tolerance = '0;
    geo_bus.valid = 1'b0;
    geo_bus.sin_incident = '0;
    geo_bus.cos_incident = '0;
    geo_bus.sin_scattered = '0;
    geo_bus.cos_scattered = '0;
    geo_bus.sin_azimuth = '0;
    geo_bus.cos_azimuth = '0;
    rot_bus.ready = 1'b0;
  end

  // Receiver: toggle ready at random, compare each accepted beat with the oldest prediction.
  always @(posedge clk_i) begin
    rotation_t want;
    if (rst_ni) begin
      if (rot_bus.valid && rot_bus.ready) begin
        if (expected_rotations.size() == 0) begin
          $error("result beat with no prediction waiting");
          error_count++;
        end else begin
          want = expected_rotations.pop_front();
          if (rot_bus.sin_double_angle !== want.s2) begin
            $error("sin_double_angle expected %0d actual %0d", want.s2,
                   rot_bus.sin_double_angle);
            error_count++;
          end
          if (rot_bus.cos_double_angle !== want.c2) begin
            $error("cos_double_angle expected %0d actual %0d", want.c2,
                   rot_bus.cos_double_angle);
            error_count++;
          end
          if (rot_bus.degenerate !== want.degen) begin
            $error("degenerate expected %0d actual %0d", want.degen, rot_bus.degenerate);
            error_count++;
          end
        end
      end
      rot_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((geo_bus.valid && geo_bus.ready) || (rot_bus.valid && rot_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Send one geometry beat; predict at acceptance time using the current tolerance.
  // Valid stays high after the beat so the next one can follow back to back.
  task automatic send_geometry(geometry_t g);
    if ($urandom_range(99) < send_idle_pct) begin
      geo_bus.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    geo_bus.valid <= 1'b1;
    geo_bus.sin_incident <= g.si;
    geo_bus.cos_incident <= g.ci;
    geo_bus.sin_scattered <= g.ss;
    geo_bus.cos_scattered <= g.cs;
    geo_bus.sin_azimuth <= g.sa;
    geo_bus.cos_azimuth <= g.ca;
    do @(posedge clk_i); while (!geo_bus.ready);
    expected_rotations.push_back(predict_rotation(g, tolerance));
  endtask

  // Drop valid, drain the pipe, then write the tolerance register.
  task automatic write_tolerance(int value);
    geo_bus.valid <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.near_tolerance <= TOL_W'(value);
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    tolerance = value;
  endtask

  function automatic logic signed [FW-1:0] unit_value();
    return FW'($urandom_range(2 * ONE_I) - ONE_I);
  endfunction

  // Pick a value near plus or minus one, within a few LSBs of the tolerance margin.
  function automatic logic signed [FW-1:0] near_unit();
    int v;
    v = ONE_I - int'($urandom_range(tolerance + 3));
    return FW'($urandom_range(1) ? v : -v);
  endfunction

  // Random geometry: mostly in range with mixed axis cases, some raw 18-bit noise.
  function automatic geometry_t random_geometry();
    geometry_t g;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      g = geometry_t'({$urandom, $urandom, $urandom, $urandom});
    end else begin
      g.si = unit_value(); g.ci = unit_value();
      g.ss = unit_value(); g.cs = unit_value();
      g.sa = unit_value(); g.ca = unit_value();
      if (pick < 25) g.ci = near_unit();
      else if (pick < 40) g.cs = near_unit();
      else if (pick < 45) begin
        g.ci = near_unit();
        g.cs = near_unit();
      end else if (pick < 52) g.sa = FW'(int'($urandom_range(2 * tolerance + 4)) - tolerance - 2);
      else if (pick < 56) g.ss = '0;
      else if (pick < 60) begin
        // incident and scattered zenith made equal, azimuth cosine plus or minus one
        g.cs = g.ci;
        g.ss = g.si;
        g.ca = $urandom_range(1) ? FW'(ONE_I) : -FW'(ONE_I);
      end
    end
    return g;
  endfunction

  task automatic test_directed_corners();
    geometry_t g;
    send_geometry('{si: 0, ci: FW'(ONE_I), ss: 0, cs: FW'(ONE_I), sa: 100, ca: 0});
    send_geometry('{si: 30000, ci: 40000, ss: 30000, cs: 40000, sa: 0, ca: FW'(ONE_I)});
    send_geometry('{si: 0, ci: -FW'(ONE_I), ss: 46341, cs: 46341, sa: 46341, ca: 46341});
    send_geometry('{si: 46341, ci: 46341, ss: 0, cs: FW'(ONE_I), sa: 30000, ca: -50000});
    send_geometry('{si: 46341, ci: 46341, ss: 0, cs: -FW'(ONE_I), sa: -30000, ca: 50000});
    send_geometry('{si: 40000, ci: 30000, ss: 0, cs: 30000, sa: 20000, ca: 60000});
    send_geometry('{si: 46341, ci: 46341, ss: 46341, cs: 46341, sa: 1, ca: FW'(ONE_I)});
    send_geometry('{si: 30000, ci: 50000, ss: 40000, cs: -20000, sa: 50000, ca: -30000});
    send_geometry('{si: FW'(ONE_I), ci: 0, ss: FW'(ONE_I), cs: 0, sa: FW'(ONE_I), ca: 0});
    send_geometry('{si: -FW'(ONE_I), ci: 0, ss: -FW'(ONE_I), cs: 0,
                    sa: -FW'(ONE_I), ca: -FW'(ONE_I)});
    send_geometry('{si: 18'sh1ffff, ci: 18'sh1ffff, ss: 18'sh1ffff, cs: 18'sh1ffff,
                    sa: 18'sh1ffff, ca: 18'sh1ffff});
    send_geometry('{si: 18'sh20000, ci: 18'sh20000, ss: 18'sh20000, cs: 18'sh20000,
                    sa: 18'sh20000, ca: 18'sh20000});
    send_geometry('{si: 100, ci: 5, ss: 100, cs: 7, sa: -FW'(ONE_I), ca: 3});
    g = '{si: 1, ci: 65535, ss: 20000, cs: 30000, sa: 40000, ca: 50000};
    send_geometry(g);
  endtask

  task automatic test_random_geometries(int count);
    repeat (count) send_geometry(random_geometry());
  endtask

  task automatic test_tolerance_settings();
    int settings[5] = '{0, 1024, 37, 512, 1};
    foreach (settings[i]) begin
      write_tolerance(settings[i]);
      test_directed_corners();
      test_random_geometries(40);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 37; recv_idle_pct = 72;
    test_directed_corners();
    test_random_geometries(300);
    test_tolerance_settings();
    send_idle_pct = 72; recv_idle_pct = 37;
    write_tolerance(8);
    test_random_geometries(300);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_tolerance(200);
    test_random_geometries(220);
    geo_bus.valid <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
